// ----- design/srge_pkg.sv -----
package srge_pkg;

    localparam int GAP_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int TOKEN_W    = 9;
    localparam int STREAM_W   = 2;
    localparam int SLOT_N     = 10;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    localparam logic [GAP_W-1:0]  MAX_ROWS  = 9'd256;
    localparam logic [BYTE_W-1:0] STOP_NOTE = 8'd255;

    // Stream codes on the output tuser
    localparam logic [STREAM_W-1:0] STREAM_NOTE   = 2'd0;
    localparam logic [STREAM_W-1:0] STREAM_VOLUME = 2'd1;
    localparam logic [STREAM_W-1:0] STREAM_EFFECT = 2'd2;

    // Token slots of one row, in send order
    localparam int SLOT_NOTE_GAP   = 0;
    localparam int SLOT_NOTE_VAL   = 1;
    localparam int SLOT_NOTE_INST  = 2;
    localparam int SLOT_VOL_GAP    = 3;
    localparam int SLOT_VOL_VAL    = 4;
    localparam int SLOT_EFF_GAP    = 5;
    localparam int SLOT_EFF_VAL    = 6;
    localparam int SLOT_NOTE_FINAL = 7;
    localparam int SLOT_VOL_FINAL  = 8;
    localparam int SLOT_EFF_FINAL  = 9;

    // One classified row. Each gap field holds the gap to send for that
    // stream: the count before the row when the field is present, the grown
    // count otherwise (the only case with a closing full-count token).
    typedef struct packed {
        logic [SLOT_N-1:0] mask;
        logic [GAP_W-1:0]  note_gap;
        logic [BYTE_W-1:0] note;
        logic [BYTE_W-1:0] instrument;
        logic [GAP_W-1:0]  volume_gap;
        logic [BYTE_W-1:0] volume;
        logic [GAP_W-1:0]  effect_gap;
        logic [BYTE_W-1:0] effect;
    } job_t;

    function automatic logic [GAP_W-1:0] grow_gap(input logic [GAP_W-1:0] gap);
        logic [GAP_W-1:0] res;
        res = (gap < MAX_ROWS) ? gap + GAP_W'(1) : MAX_ROWS;
        return res;
    endfunction

endpackage

// ----- design/srge_front.sv -----
module srge_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [srge_pkg::S_TDATA_W-1:0] in_data,
    input  logic                           in_last,
    output logic                           push,
    output srge_pkg::job_t                 job,
    input  logic                           q_full
);
    import srge_pkg::*;

    logic [GAP_W-1:0] note_gap_reg, note_gap_next;
    logic [GAP_W-1:0] volume_gap_reg, volume_gap_next;
    logic [GAP_W-1:0] effect_gap_reg, effect_gap_next;
    logic note_used_reg, note_used_next;
    logic volume_used_reg, volume_used_next;
    logic effect_used_reg, effect_used_next;

    logic              np, vp, ep, accept;
    logic [BYTE_W-1:0] nv, inst, vv, ev;
    logic [GAP_W-1:0]  note_grown, volume_grown, effect_grown;

    assign np   = in_data[0];
    assign nv   = in_data[8:1];
    assign inst = in_data[16:9];
    assign vp   = in_data[17];
    assign vv   = in_data[25:18];
    assign ep   = in_data[26];
    assign ev   = in_data[34:27];

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign note_grown   = grow_gap(note_gap_reg);
    assign volume_grown = grow_gap(volume_gap_reg);
    assign effect_grown = grow_gap(effect_gap_reg);

    always_comb
    begin
        job.note_gap   = np ? note_gap_reg : note_grown;
        job.note       = nv;
        job.instrument = inst;
        job.volume_gap = vp ? volume_gap_reg : volume_grown;
        job.volume     = vv;
        job.effect_gap = ep ? effect_gap_reg : effect_grown;
        job.effect     = ev;

        job.mask                  = '0;
        job.mask[SLOT_NOTE_GAP]   = np;
        job.mask[SLOT_NOTE_VAL]   = np;
        job.mask[SLOT_NOTE_INST]  = np && (nv != STOP_NOTE);
        job.mask[SLOT_VOL_GAP]    = vp;
        job.mask[SLOT_VOL_VAL]    = vp;
        job.mask[SLOT_EFF_GAP]    = ep;
        job.mask[SLOT_EFF_VAL]    = ep;
        job.mask[SLOT_NOTE_FINAL] = in_last && !note_used_reg && !np;
        job.mask[SLOT_VOL_FINAL]  = in_last && !volume_used_reg && !vp;
        job.mask[SLOT_EFF_FINAL]  = in_last && !effect_used_reg && !ep;
    end

    // Rows with no token only advance or clear the gap counts
    assign push = accept && (job.mask != '0);

    always_comb
    begin
        note_gap_next    = note_gap_reg;
        volume_gap_next  = volume_gap_reg;
        effect_gap_next  = effect_gap_reg;
        note_used_next   = note_used_reg;
        volume_used_next = volume_used_reg;
        effect_used_next = effect_used_reg;
        if (accept)
        begin
            if (in_last)
            begin
                note_gap_next    = '0;
                volume_gap_next  = '0;
                effect_gap_next  = '0;
                note_used_next   = 1'b0;
                volume_used_next = 1'b0;
                effect_used_next = 1'b0;
            end
            else
            begin
                note_gap_next    = np ? '0 : note_grown;
                volume_gap_next  = vp ? '0 : volume_grown;
                effect_gap_next  = ep ? '0 : effect_grown;
                note_used_next   = note_used_reg || np;
                volume_used_next = volume_used_reg || vp;
                effect_used_next = effect_used_reg || ep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_gap_reg    <= '0;
            volume_gap_reg  <= '0;
            effect_gap_reg  <= '0;
            note_used_reg   <= 1'b0;
            volume_used_reg <= 1'b0;
            effect_used_reg <= 1'b0;
        end
        else
        begin
            note_gap_reg    <= note_gap_next;
            volume_gap_reg  <= volume_gap_next;
            effect_gap_reg  <= effect_gap_next;
            note_used_reg   <= note_used_next;
            volume_used_reg <= volume_used_next;
            effect_used_reg <= effect_used_next;
        end
    end

endmodule

// ----- design/srge_queue.sv -----
module srge_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  srge_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output srge_pkg::job_t head_job
);
    import srge_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
`endif

endmodule

// ----- design/srge_back.sv -----
module srge_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           head_valid,
    input  srge_pkg::job_t                 head_job,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [srge_pkg::M_TDATA_W-1:0] out_data,
    output logic [srge_pkg::STREAM_W-1:0]  out_user,
    output logic                           out_last
);
    import srge_pkg::*;

    logic [SLOT_N-1:0]   sent_reg, sent_next;
    logic                valid_reg, valid_next;
    logic [TOKEN_W-1:0]  token_reg;
    logic [STREAM_W-1:0] stream_reg;
    logic                last_reg;

    logic [SLOT_N-1:0]   pend, pick;
    logic [TOKEN_W-1:0]  tok;
    logic [STREAM_W-1:0] strm;
    logic                tok_last, load;

    assign pend     = head_job.mask & ~sent_reg;
    assign pick     = pend & (~pend + SLOT_N'(1));
    assign tok_last = ((pend & ~pick) == '0);

    always_comb
    begin
        tok  = '0;
        strm = STREAM_NOTE;
        if (pick[SLOT_NOTE_GAP] || pick[SLOT_NOTE_FINAL])
        begin
            tok = head_job.note_gap;
        end
        if (pick[SLOT_NOTE_VAL])
        begin
            tok = {1'b0, head_job.note};
        end
        if (pick[SLOT_NOTE_INST])
        begin
            tok = {1'b0, head_job.instrument};
        end
        if (pick[SLOT_VOL_GAP] || pick[SLOT_VOL_FINAL])
        begin
            tok  = head_job.volume_gap;
            strm = STREAM_VOLUME;
        end
        if (pick[SLOT_VOL_VAL])
        begin
            tok  = {1'b0, head_job.volume};
            strm = STREAM_VOLUME;
        end
        if (pick[SLOT_EFF_GAP] || pick[SLOT_EFF_FINAL])
        begin
            tok  = head_job.effect_gap;
            strm = STREAM_EFFECT;
        end
        if (pick[SLOT_EFF_VAL])
        begin
            tok  = {1'b0, head_job.effect};
            strm = STREAM_EFFECT;
        end
    end

    // Refill the output register whenever it is empty or being drained
    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && tok_last;

    always_comb
    begin
        sent_next  = sent_reg;
        valid_next = valid_reg;
        if (load)
        begin
            sent_next  = tok_last ? '0 : (sent_reg | pick);
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg  <= sent_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            token_reg  <= tok;
            stream_reg <= strm;
            last_reg   <= tok_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {{(M_TDATA_W - TOKEN_W){1'b0}}, token_reg};
    assign out_user  = stream_reg;
    assign out_last  = last_reg;

`ifndef SYNTHESIS
    a_pending_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (pend != '0))
        else $error("queued row has no token left to send");

    a_sent_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (sent_reg == '0))
        else $error("sent slots not cleared after row end");
`endif

endmodule

// ----- design/sparse_row_gap_encoder_unit.sv -----
// Sparse row gap encoder: zero run-length coding of one pattern channel.
// Input channel (s_axis_*): one pattern row per transfer; tlast marks the
// final row of the pattern. Output channel (m_axis_*): one token per
// transfer, tuser names the target stream (notes, volumes, effects) and
// tlast marks the final token caused by a row.
// A row with a field sends the stream's gap count and the value (and the
// instrument after a note other than the stop note); the final row closes
// each stream that never sent anything with a full-count gap token.
// With the queue empty, a row's transfer is written into the queue, then
// its first token is loaded into the output register and m_axis_tvalid
// rises. The single output register sends one token per cycle while
// m_axis_tready is high; a row causes up to seven tokens, and a row that
// causes no token is not queued. A two-entry queue separates row
// classification from token serialization, so new rows are taken while
// tokens drain. When m_axis_tready is low the output register holds its
// token, the queue fills and s_axis_tready drops. Reset clears the gap counts,
// stream-used flags, queue and output valid flag; there is no clearing pass.
module sparse_row_gap_encoder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // note_present, note, instrument, volume_present, volume,
    // effect_present, effect, zero fill
    input  logic [srge_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // token, zero fill
    output logic [srge_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // stream
    output logic [srge_pkg::STREAM_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast
);
    import srge_pkg::*;

    job_t push_job, head_job;
    logic push, q_full, pop, head_valid;

    // Classify rows and keep the per-stream gap state
    srge_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .push     (push),
        .job      (push_job),
        .q_full   (q_full)
    );

    // Hold classified rows between the two halves
    srge_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Send one token per transfer, in stream order
    srge_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import srge_pkg::*;

    // One pattern row as the encoder sees it
    typedef struct packed {
        logic              note_present;
        logic [BYTE_W-1:0] note;
        logic [BYTE_W-1:0] instrument;
        logic              volume_present;
        logic [BYTE_W-1:0] volume;
        logic              effect_present;
        logic [BYTE_W-1:0] effect;
        logic              last_row;
    } row_t;

    // A queued row; drain_first holds it back until every token has come out
    typedef struct packed {
        row_t row;
        logic drain_first;
    } pending_row_t;

    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [TOKEN_W-1:0]  token;
        logic                last_of_row;
    } gap_token_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int CHOKE_AFTER    = 60;   // tokens seen before the long hold-off
    localparam int CHOKE_CYCLES   = 200;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_ROWS    = 100;

    logic clk;
    logic rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STREAM_W-1:0]  m_axis_tuser;
    logic                 m_axis_tlast;

    sparse_row_gap_encoder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    pending_row_t pending_rows[$];
    gap_token_t   expected_tokens[$];
    int           fail_count = 0;

    // Gap counts and used flags of the encoder, tracked alongside it
    logic [GAP_W-1:0] note_gap_cnt   = '0;
    logic [GAP_W-1:0] volume_gap_cnt = '0;
    logic [GAP_W-1:0] effect_gap_cnt = '0;
    logic             note_sent      = 1'b0;
    logic             volume_sent    = 1'b0;
    logic             effect_sent    = 1'b0;

    // Handshake flags captured at the rising edge, used at the falling edge
    logic row_taken   = 1'b0;
    logic token_taken = 1'b0;
    row_t offered_row = '0;

    function automatic logic [GAP_W-1:0] saturate_gap(input logic [GAP_W-1:0] gap);
        return (gap < MAX_ROWS) ? gap + GAP_W'(1) : MAX_ROWS;
    endfunction

    function automatic void push_token(input logic [STREAM_W-1:0] stream,
                                       input logic [TOKEN_W-1:0] value);
        gap_token_t t;
        t.stream      = stream;
        t.token       = value;
        t.last_of_row = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    // Work out the tokens that one accepted row causes and advance the counts
    function automatic void encode_row(input row_t r);
        int first;
        first = expected_tokens.size();
        if (r.note_present)
        begin
            push_token(STREAM_NOTE, note_gap_cnt);
            push_token(STREAM_NOTE, {1'b0, r.note});
            // the stop note carries no instrument
            if (r.note != STOP_NOTE)
                push_token(STREAM_NOTE, {1'b0, r.instrument});
            note_gap_cnt = '0;
            note_sent    = 1'b1;
        end
        else
            note_gap_cnt = saturate_gap(note_gap_cnt);
        if (r.volume_present)
        begin
            push_token(STREAM_VOLUME, volume_gap_cnt);
            push_token(STREAM_VOLUME, {1'b0, r.volume});
            volume_gap_cnt = '0;
            volume_sent    = 1'b1;
        end
        else
            volume_gap_cnt = saturate_gap(volume_gap_cnt);
        if (r.effect_present)
        begin
            push_token(STREAM_EFFECT, effect_gap_cnt);
            push_token(STREAM_EFFECT, {1'b0, r.effect});
            effect_gap_cnt = '0;
            effect_sent    = 1'b1;
        end
        else
            effect_gap_cnt = saturate_gap(effect_gap_cnt);
        // close the pattern: streams that stayed silent send their full count
        if (r.last_row)
        begin
            if (!note_sent)
                push_token(STREAM_NOTE, note_gap_cnt);
            if (!volume_sent)
                push_token(STREAM_VOLUME, volume_gap_cnt);
            if (!effect_sent)
                push_token(STREAM_EFFECT, effect_gap_cnt);
            note_gap_cnt   = '0;
            volume_gap_cnt = '0;
            effect_gap_cnt = '0;
            note_sent      = 1'b0;
            volume_sent    = 1'b0;
            effect_sent    = 1'b0;
        end
        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last_of_row = 1'b1;
    endfunction

    function automatic row_t make_row(input logic np, input int n, input int inst,
                                      input logic vp, input int v,
                                      input logic ep, input int e, input logic last);
        row_t r;
        r.note_present   = np;
        r.note           = BYTE_W'(n);
        r.instrument     = BYTE_W'(inst);
        r.volume_present = vp;
        r.volume         = BYTE_W'(v);
        r.effect_present = ep;
        r.effect         = BYTE_W'(e);
        r.last_row       = last;
        return r;
    endfunction

    function automatic void queue_row(input row_t r, input logic drain_first);
        pending_row_t p;
        p.row         = r;
        p.drain_first = drain_first;
        pending_rows.push_back(p);
    endfunction

    // Idle cycles before the next transfer; flip now and then into a run of
    // back-to-back transfers so both dense and sparse traffic occur
    function automatic int idle_draw(inout bit fast);
        if ($urandom_range(0, 15) == 0)
            fast = !fast;
        return fast ? 0 : $urandom_range(0, 10);
    endfunction

    // Capture handshakes, advance the predictor and check each token
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            row_taken   <= s_axis_tvalid && s_axis_tready;
            token_taken <= m_axis_tvalid && m_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token: stream %0d token %0d last %0b",
                             $realtime, m_axis_tuser, m_axis_tdata[TOKEN_W-1:0],
                             m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    if (m_axis_tuser != expected_tokens[0].stream)
                    begin
                        $display("%0t: stream mismatch: expected %0d actual %0d",
                                 $realtime, expected_tokens[0].stream, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[TOKEN_W-1:0] != expected_tokens[0].token)
                    begin
                        $display("%0t: token mismatch: expected %0d actual %0d",
                                 $realtime, expected_tokens[0].token,
                                 m_axis_tdata[TOKEN_W-1:0]);
                        fail_count++;
                    end
                    if (m_axis_tlast != expected_tokens[0].last_of_row)
                    begin
                        $display("%0t: last_of_row mismatch: expected %0b actual %0b",
                                 $realtime, expected_tokens[0].last_of_row, m_axis_tlast);
                        fail_count++;
                    end
                    void'(expected_tokens.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                encode_row(offered_row);
        end
    end

    // Row driver: hold the offered row until taken, then wait a drawn number
    // of idle cycles before offering the next one
    int sender_idle = 0;
    bit sender_fast = 1'b0;
    pending_row_t next_row;

    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !row_taken))
        begin
            if (row_taken)
                sender_idle = idle_draw(sender_fast);
            if (sender_idle > 0)
            begin
                sender_idle--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_rows.size() > 0 &&
                     !(pending_rows[0].drain_first && expected_tokens.size() > 0))
            begin
                next_row = pending_rows.pop_front();
                offered_row   <= next_row.row;
                s_axis_tdata  <= {5'b0, next_row.row.effect, next_row.row.effect_present,
                                  next_row.row.volume, next_row.row.volume_present,
                                  next_row.row.instrument, next_row.row.note,
                                  next_row.row.note_present};
                s_axis_tlast  <= next_row.row.last_row;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Token receiver: stall a drawn number of cycles per token, and once hold
    // off for a long stretch so the encoder backs up into its input
    int receiver_hold = 0;
    int tokens_seen   = 0;
    bit receiver_fast = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (token_taken)
            begin
                tokens_seen++;
                if (tokens_seen == CHOKE_AFTER)
                    receiver_hold = CHOKE_CYCLES;
                else
                    receiver_hold = idle_draw(receiver_fast);
            end
            if (receiver_hold > 0)
            begin
                receiver_hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Drop the run if neither side moves a transfer for too long
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    int queued;
    int plen;
    int pat_idx;
    int note_density;
    int vol_density;
    int eff_density;
    row_t r;

    initial
    begin
        // Directed: growing gaps, then every field at both extremes
        queue_row(make_row(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        queue_row(make_row(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        queue_row(make_row(1, 0, 0, 1, 0, 1, 0, 0), 1'b0);
        // stop note: no instrument follows
        queue_row(make_row(1, 255, 'hAA, 0, 0, 0, 0, 0), 1'b0);
        // busiest row: seven tokens, ends the pattern with no closing gaps
        queue_row(make_row(1, 254, 255, 1, 255, 1, 255, 1), 1'b0);
        // pattern that never sends anything until its last row
        queue_row(make_row(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        queue_row(make_row(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        queue_row(make_row(0, 'h12, 'h34, 0, 'h56, 0, 'h78, 1), 1'b0);
        // single-row patterns
        queue_row(make_row(0, 0, 0, 1, 'h5A, 0, 0, 1), 1'b0);
        queue_row(make_row(0, 'hFF, 'hFF, 0, 'hFF, 0, 'hFF, 1), 1'b0);
        queue_row(make_row(1, 255, 0, 0, 0, 0, 0, 1), 1'b0);
        // mixed: only the volume stream closes the pattern
        queue_row(make_row(0, 0, 0, 0, 0, 1, 'h81, 0), 1'b0);
        queue_row(make_row(1, 'h80, 'h01, 0, 0, 0, 0, 0), 1'b0);
        queue_row(make_row(0, 0, 0, 0, 0, 0, 0, 1), 1'b0);
        queue_row(make_row(1, 'h55, 'hAA, 1, 'hAA, 1, 'h55, 0), 1'b0);
        queue_row(make_row(0, 0, 0, 1, 'h7F, 0, 0, 0), 1'b0);
        queue_row(make_row(1, 'h01, 'h7F, 0, 0, 1, 'h80, 1), 1'b0);

        // Random patterns of short length, with per-stream density drawn per
        // pattern so silent streams and closing gaps come up often
        queued  = 0;
        pat_idx = 0;
        while (queued < RANDOM_ROWS)
        begin
            plen         = $urandom_range(1, 12);
            note_density = $urandom_range(0, 4);
            vol_density  = $urandom_range(0, 4);
            eff_density  = $urandom_range(0, 4);
            for (int i = 0; i < plen; i++)
            begin
                r = make_row($urandom_range(1, 4) <= note_density,
                             ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 255),
                             $urandom_range(0, 255),
                             $urandom_range(1, 4) <= vol_density, $urandom_range(0, 255),
                             $urandom_range(1, 4) <= eff_density, $urandom_range(0, 255),
                             i == plen - 1);
                queue_row(r, (i == 0) && (pat_idx % 6 == 5));
            end
            queued += plen;
            pat_idx++;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every row to be taken, then for every token to come out
        while (pending_rows.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_tokens.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
